// ===== sv/lpnal_pkg.sv =====
`timescale 1ns / 1ps

package lpnal_pkg;

  // Largest sample that the byte counters must hold.
  localparam int unsigned MAX_SAMPLE_BYTES = 4194304;
  localparam int unsigned SL_W  = 23;
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLE_BYTES + 1);
  localparam int unsigned CMP_W = (CNT_W > SL_W) ? CNT_W : SL_W;
  localparam int unsigned LEN_W = 32;
  localparam int unsigned HDR_LEN = 4;

  // Command queue between the front and the back.
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Result kinds.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // Start code that replaces each length field.
  localparam logic [7:0] START_CODE [HDR_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01};

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_DROP
  } phase_e;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_START,
    CMD_ERROR
  } cmd_e;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic            first_of_sample;
    logic [SL_W-1:0] sample_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       item_kind;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
  } cmd_t;

  // Queue status seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

// ===== sv/lpnal_front.sv =====
`timescale 1ns / 1ps

module lpnal_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  lpnal_pkg::in_item_t item_i,
  output logic                push_o,
  output lpnal_pkg::cmd_t     cmd_o
);
  import lpnal_pkg::*;

  phase_e             phase_q, phase_d;
  logic [1:0]         hcnt_q, hcnt_d;
  logic [LEN_W-1:0]   gather_q, gather_d;
  logic [CNT_W-1:0]   sleft_q, sleft_d;
  logic [CNT_W-1:0]   body_q, body_d;

  // State as seen after a possible start of a new sample.
  phase_e             ph_e;
  logic [1:0]         hcnt_e;
  logic [LEN_W-1:0]   gather_e;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   body_e;
  logic [CMP_W-1:0]   slen_ext;
  logic [CMP_W-1:0]   slen_clamp;
  logic [LEN_W-1:0]   gather_n;
  logic [CNT_W-1:0]   rem_m1;
  logic               short_tail;
  logic               len_bad;

  always_comb begin
    slen_ext   = CMP_W'(item_i.sample_length);
    slen_clamp = (slen_ext > CMP_W'(MAX_SAMPLE_BYTES)) ? CMP_W'(MAX_SAMPLE_BYTES) : slen_ext;
    if (item_i.first_of_sample) begin
      ph_e     = PH_HEADER;
      hcnt_e   = 2'd0;
      gather_e = '0;
      rem      = slen_clamp[CNT_W-1:0];
      body_e   = '0;
    end else begin
      ph_e     = phase_q;
      hcnt_e   = hcnt_q;
      gather_e = gather_q;
      rem      = sleft_q;
      body_e   = body_q;
    end
    gather_n   = {gather_e[LEN_W-9:0], item_i.data_byte};
    rem_m1     = rem - CNT_W'(1);
    short_tail = (hcnt_e == 2'd0) && (rem <= CNT_W'(HDR_LEN));
    len_bad    = gather_n > LEN_W'(rem_m1);
  end

  // Next state.
  always_comb begin
    phase_d  = ph_e;
    hcnt_d   = hcnt_e;
    gather_d = gather_e;
    sleft_d  = rem;
    body_d   = body_e;
    if (rem != '0) begin
      sleft_d = rem_m1;
      case (ph_e)
        PH_HEADER: begin
          if (short_tail) begin
            phase_d = PH_DROP;
          end else if (hcnt_e == 2'd3) begin
            hcnt_d   = 2'd0;
            gather_d = '0;
            if (len_bad) begin
              phase_d = PH_DROP;
            end else begin
              body_d  = gather_n[CNT_W-1:0];
              phase_d = (gather_n != '0) ? PH_BODY : PH_HEADER;
            end
          end else begin
            hcnt_d   = hcnt_e + 2'd1;
            gather_d = gather_n;
          end
        end
        PH_BODY: begin
          if (body_e != '0) begin
            body_d = body_e - CNT_W'(1);
          end
          if (body_e <= CNT_W'(1)) begin
            phase_d = PH_HEADER;
          end
        end
        default: begin
          phase_d = PH_DROP;
        end
      endcase
    end
  end

  // Command for the back part.
  always_comb begin
    push_o      = 1'b0;
    cmd_o.kind  = CMD_BYTE;
    cmd_o.data  = item_i.data_byte;
    if (fire_i && (rem != '0)) begin
      case (ph_e)
        PH_HEADER: begin
          if (!short_tail && (hcnt_e == 2'd3)) begin
            push_o     = 1'b1;
            cmd_o.kind = len_bad ? CMD_ERROR : CMD_START;
          end
        end
        PH_BODY: begin
          push_o = 1'b1;
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      hcnt_q   <= 2'd0;
      gather_q <= '0;
      sleft_q  <= '0;
      body_q   <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      hcnt_q   <= hcnt_d;
      gather_q <= gather_d;
      sleft_q  <= sleft_d;
      body_q   <= body_d;
    end
  end

  // A partly gathered length exists only in the header phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hcnt_q != 2'd0) |-> (phase_q == PH_HEADER))
    else $error("header count set outside header phase");

endmodule

// ===== sv/lpnal_fifo.sv =====
`timescale 1ns / 1ps

module lpnal_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lpnal_pkg::cmd_t      cmd_i,
  input  logic                 pop_i,
  output lpnal_pkg::cmd_t      cmd_o,
  output lpnal_pkg::q_status_t status_o
);
  import lpnal_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign status_o.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign status_o.valid = (cnt_q != '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.valid;
  assign cmd_o   = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = do_push ? QPTR_W'((wr_q + 1'b1) % QDEPTH) : wr_q;
    rd_d  = do_pop  ? QPTR_W'((rd_q + 1'b1) % QDEPTH) : rd_q;
    cnt_d = cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W+1)'(QDEPTH))
    else $error("command queue count out of range");

endmodule

// ===== sv/lpnal_back.sv =====
`timescale 1ns / 1ps

module lpnal_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpnal_pkg::cmd_t      cmd_i,
  input  lpnal_pkg::q_status_t status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lpnal_pkg::out_item_t out_data_o
);
  import lpnal_pkg::*;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic [1:0] idx_q, idx_d;
  logic      load;

  assign load        = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Expand the head command into result items.
  always_comb begin
    pop_o       = 1'b0;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load && status_i.valid) begin
      case (cmd_i.kind)
        CMD_BYTE: begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          out_d       = '{out_byte: cmd_i.data, item_kind: KIND_BYTE, last_of_run: 1'b1};
        end
        CMD_START: begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: START_CODE[idx_q], item_kind: KIND_BYTE,
                          last_of_run: (idx_q == 2'd3)};
          idx_d       = idx_q + 2'd1;
          pop_o       = (idx_q == 2'd3);
        end
        CMD_ERROR: begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          out_d       = '{out_byte: 8'h00, item_kind: KIND_ERROR, last_of_run: 1'b1};
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // A start code in progress keeps its command at the queue head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> (status_i.valid && (cmd_i.kind == CMD_START)))
    else $error("start code interrupted");

  // An error item is a zero byte that ends its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.item_kind == KIND_ERROR)) |->
      ((out_q.out_byte == 8'h00) && out_q.last_of_run))
    else $error("malformed error item");

endmodule

// ===== sv/length_prefixed_nal_to_start_code.sv =====
`timescale 1ns / 1ps
// With an empty queue, an input transfer's first result is registered in the queue and
// then in the output register; later start code bytes follow one per cycle while ready.
// Throughput: one input byte per cycle while the output is ready; a length header's fourth
// byte yields four start code bytes, which the back part sends one per cycle from an
// 8-entry queue that absorbs them. The queue depth sets how long the input keeps accepting
// while the output is stalled.
// Reset (rst_ni low, asynchronous) clears the queue, output valid and sample state.
module length_prefixed_nal_to_start_code (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lpnal_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lpnal_pkg::out_item_t out_data_o
);
  import lpnal_pkg::*;

  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      push;
  logic      pop;
  logic      fire;

  assign in_ready_o = !q_status.full;
  assign fire       = in_valid_i && in_ready_o;

  lpnal_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_data_i),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  lpnal_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  lpnal_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
